[hw/rtl/rs485ml_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485ml_pkg
// Shared types and constants of the RS-485 half-duplex master link.
// ----------------------------------------------------------------------------
package rs485ml_pkg;

  // Event kinds carried on the input channel.
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RX_BYTE = 2'd2,
    CMD_TX_SLOT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TX   = 2'd1,
    PH_RX   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DONE_REPLY      = 2'd0,
    DONE_RX_TIMEOUT = 2'd1,
    DONE_TX_TIMEOUT = 2'd2
  } done_t;

  // Configuration register indexes.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] REG_TX_COUNT      = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_RX_COUNT      = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_TX_TIMEOUT    = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_RX_TIMEOUT    = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_MAX_TX_ERRORS = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_MAX_RX_ERRORS = 3'd5;

  // Depth of the queue between front and back.
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int OutDataW = 64;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  tx_count;
    logic [7:0]  rx_count;
    logic [15:0] tx_timeout;
    logic [15:0] rx_timeout;
    logic [7:0]  max_tx_errors;
    logic [7:0]  max_rx_errors;
  } cfg_t;

  // Result layout, last member in the lowest bits of tdata.
  typedef struct packed {
    logic [15:0] rx_error_total;
    logic [15:0] tx_error_total;
    phase_t      phase_now;
    logic        link_fail;
    done_t       done_code;
    logic [7:0]  rx_index;
    logic [7:0]  rx_data;
    logic        rx_valid;
    logic [7:0]  tx_data;
    logic        tx_valid;
    logic        driver_enable;
  } result_t;

  // Handshake between queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

[hw/rtl/rs485ml_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485ml_front
// Input stage: takes event beats, decodes the event kind and hands them on.
// ----------------------------------------------------------------------------
module rs485ml_front
  import rs485ml_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  output logic       push,
  output item_t      push_item,
  input  q_status_t  q_status
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  // The stage empties whenever the queue has room, so it can refill each cycle.
  assign push      = valid_r && !q_status.full;
  assign in_tready = !valid_r || !q_status.full;
  assign take      = in_tvalid && in_tready;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.cmd  <= cmd_t'(in_tuser);
      item_r.data <= in_tdata;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rs485ml_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485ml_queue
// Short FIFO that decouples the input stage from the sequencer.
// ----------------------------------------------------------------------------
module rs485ml_queue
  import rs485ml_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t q_status
);

  item_t            slots_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_status.full  = (count_r == QCntW'(QDepth));
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCntW'(QDepth))
    else $error("queue count above depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !push)
    else $error("push offered while queue full");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - QCntW'(1)))
    else $error("pop did not lower the count");
`endif

endmodule
`default_nettype wire

[hw/rtl/rs485ml_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485ml_back
// Transaction sequencer: applies one event per cycle to the link state and
// registers the result beat, unless the queue is empty or the output is stalled.
// ----------------------------------------------------------------------------
module rs485ml_back
  import rs485ml_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  item_t               head,
  input  q_status_t           q_status,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  rx_pos_r, rx_pos_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  tx_run_r, tx_run_nxt;
  logic [7:0]  rx_run_r, rx_run_nxt;
  logic        fail_r, fail_nxt;
  logic [15:0] tx_stat_r, tx_stat_nxt;
  logic [15:0] rx_stat_r, rx_stat_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res;
  logic        done_r, done;

  logic [15:0] timer_inc;
  logic [7:0]  tx_run_inc, rx_run_inc;
  logic [7:0]  bytes_dec;

  assign pop        = !q_status.empty && (!out_valid_r || out_tready);
  assign timer_inc  = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;
  assign tx_run_inc = (tx_run_r == 8'hFF) ? tx_run_r : tx_run_r + 8'd1;
  assign rx_run_inc = (rx_run_r == 8'hFF) ? rx_run_r : rx_run_r + 8'd1;
  assign bytes_dec  = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    rx_pos_nxt     = rx_pos_r;
    timer_nxt      = timer_r;
    tx_run_nxt     = tx_run_r;
    rx_run_nxt     = rx_run_r;
    fail_nxt       = fail_r;
    tx_stat_nxt    = tx_stat_r;
    rx_stat_nxt    = rx_stat_r;
    res            = '0;
    done           = 1'b0;

    unique case (head.cmd)
      CMD_START: begin
        if (phase_r == PH_IDLE) begin
          res.tx_valid   = 1'b1;
          res.tx_data    = head.data;
          bytes_left_nxt = cfg.tx_count;
          timer_nxt      = '0;
          phase_nxt      = PH_TX;
        end
      end
      CMD_TX_SLOT: begin
        if (phase_r == PH_TX) begin
          if (bytes_left_r != '0) begin
            res.tx_valid   = 1'b1;
            res.tx_data    = head.data;
            bytes_left_nxt = bytes_dec;
          end else begin
            // Turnaround: all request bytes are out, start listening.
            tx_run_nxt     = '0;
            bytes_left_nxt = cfg.rx_count;
            rx_pos_nxt     = '0;
            timer_nxt      = '0;
            phase_nxt      = PH_RX;
          end
        end
      end
      CMD_RX_BYTE: begin
        if (phase_r == PH_RX && bytes_left_r != '0) begin
          res.rx_valid   = 1'b1;
          res.rx_data    = head.data;
          res.rx_index   = rx_pos_r;
          rx_pos_nxt     = rx_pos_r + 8'd1;
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == '0) begin
            rx_run_nxt     = '0;
            fail_nxt       = 1'b0;
            done           = 1'b1;
            res.done_code  = DONE_REPLY;
            phase_nxt      = PH_IDLE;
          end
        end
      end
      CMD_TICK: begin
        if (phase_r != PH_IDLE) begin
          timer_nxt = timer_inc;
          if (phase_r == PH_TX && timer_inc >= cfg.tx_timeout) begin
            bytes_left_nxt = '0;
            tx_run_nxt     = tx_run_inc;
            if (tx_run_inc >= cfg.max_tx_errors) begin
              fail_nxt = 1'b1;
            end
            tx_stat_nxt   = tx_stat_r + 16'd1;
            done          = 1'b1;
            res.done_code = DONE_TX_TIMEOUT;
            phase_nxt     = PH_IDLE;
          end else if (phase_r == PH_RX && timer_inc >= cfg.rx_timeout) begin
            bytes_left_nxt = '0;
            rx_run_nxt     = rx_run_inc;
            if (rx_run_inc >= cfg.max_rx_errors) begin
              fail_nxt = 1'b1;
            end
            rx_stat_nxt   = rx_stat_r + 16'd1;
            done          = 1'b1;
            res.done_code = DONE_RX_TIMEOUT;
            phase_nxt     = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    res.driver_enable  = (phase_nxt != PH_RX);
    res.link_fail      = fail_nxt;
    res.phase_now      = phase_nxt;
    res.tx_error_total = tx_stat_nxt;
    res.rx_error_total = rx_stat_nxt;

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bytes_left_r <= '0;
      rx_pos_r     <= '0;
      timer_r      <= '0;
      tx_run_r     <= '0;
      rx_run_r     <= '0;
      fail_r       <= 1'b0;
      tx_stat_r    <= '0;
      rx_stat_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        rx_pos_r     <= rx_pos_nxt;
        timer_r      <= timer_nxt;
        tx_run_r     <= tx_run_nxt;
        rx_run_r     <= rx_run_nxt;
        fail_r       <= fail_nxt;
        tx_stat_r    <= tx_stat_nxt;
        rx_stat_r    <= rx_stat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r  <= res;
      done_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign out_tlast  = done_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (res_r.phase_now == PH_IDLE))
    else $error("transaction end reported outside idle");
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.tx_valid && res_r.rx_valid))
    else $error("transmit and receive byte in one beat");
  a_reply_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r && res_r.done_code == DONE_REPLY) |-> res_r.rx_valid)
    else $error("reply completed without a received byte");
  a_listen_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.rx_valid && !done_r) |-> !res_r.driver_enable)
    else $error("driver enabled while reply still open");
`endif

endmodule
`default_nettype wire

[hw/rtl/rs485_half_duplex_master_link.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485_half_duplex_master_link
// Request/response sequencer for an RS-485 master on a half-duplex line.
// ----------------------------------------------------------------------------
// Every input beat is one event (start, tick, received byte, transmit slot),
// and every accepted beat yields exactly one result beat, in order. The block
// takes one event per clock when the result side keeps up. Each event passes
// the input stage, the two-entry queue and output register, and the sequencer
// updates the whole link state as it registers the result beat. The queue
// and input stage keep taking beats while the result side is stalled, until
// they are full. The result beat carries the line direction, the byte to
// send, the accepted reply byte with its position, the transaction status,
// the link-fail flag, the phase after the event and the wrapping timeout
// totals; tlast marks the beat that ends a transaction. Configuration
// registers are to be written through the plain write port only while the
// block is idle, not enforced by the block; writes apply from the next event.
// ----------------------------------------------------------------------------
module rs485_half_duplex_master_link
  import rs485ml_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Event channel.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte[7:0]
  input  logic [1:0]          in_tuser,   // command[1:0]
  // Result channel.
  output logic                out_tvalid,
  input  logic                out_tready,
  // driver_enable[0], tx_valid[1], tx_data[9:2], rx_valid[10],
  // rx_data[18:11], rx_index[26:19], done_code[28:27], link_fail[29],
  // phase_now[31:30], tx_error_total[47:32], rx_error_total[63:48]
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast,  // done_valid
  // Configuration write port.
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  logic      push, pop;
  item_t     push_item, head;
  q_status_t q_status;

  // Register file; writes to unused indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TX_COUNT:      cfg_nxt.tx_count      = cfg_wdata[7:0];
        REG_RX_COUNT:      cfg_nxt.rx_count      = cfg_wdata[7:0];
        REG_TX_TIMEOUT:    cfg_nxt.tx_timeout    = cfg_wdata;
        REG_RX_TIMEOUT:    cfg_nxt.rx_timeout    = cfg_wdata;
        REG_MAX_TX_ERRORS: cfg_nxt.max_tx_errors = cfg_wdata[7:0];
        REG_MAX_RX_ERRORS: cfg_nxt.max_rx_errors = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_count      <= 8'd16;
      cfg_r.rx_count      <= 8'd17;
      cfg_r.tx_timeout    <= 16'd100;
      cfg_r.rx_timeout    <= 16'd100;
      cfg_r.max_tx_errors <= 8'd3;
      cfg_r.max_rx_errors <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rs485ml_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_item (push_item),
    .q_status  (q_status)
  );

  rs485ml_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  rs485ml_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

[bench/rs485_half_duplex_master_link_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_half_duplex_master_link_tb
// Self-checking bench for the RS-485 half-duplex master link sequencer.
// ----------------------------------------------------------------------------
// Event beats (start, tick, received byte, transmit slot) are queued by the
// stimulus block and fed to the block by a driver with random gaps. Each
// accepted event is run through a cycle-free model of the link sequencer
// kept in this bench, and the resulting beat is queued as the expected
// result. The monitor checks every result beat field by field against the
// oldest expected one. The run steps through several link settings: a short
// directed pass over the corner cases, one largest-frame exchange and random
// transactions: most well formed, some cut short and some plain noise.
// ----------------------------------------------------------------------------
module rs485_half_duplex_master_link_tb;
  import rs485ml_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // longest deliberate quiet stretch is the receiver hold-off.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  // Expected result beat: the packed tdata layout plus the tlast bit.
  typedef struct packed {
    logic    done;
    result_t res;
  } link_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // data_byte[7:0]
  logic [1:0]          in_tuser = '0;   // command[1:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // driver_enable[0], tx_valid[1], tx_data[9:2], rx_valid[10],
  // rx_data[18:11], rx_index[26:19], done_code[28:27], link_fail[29],
  // phase_now[31:30], tx_error_total[47:32], rx_error_total[63:48]
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;       // done_valid
  logic                cfg_wr_en = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  rs485_half_duplex_master_link uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Link model state and the shadow copy of the configuration registers.
  // --------------------------------------------------------------------------
  cfg_t        link_cfg;
  phase_t      link_phase = PH_IDLE;
  logic [7:0]  bytes_left = '0;
  logic [7:0]  reply_pos = '0;
  logic [15:0] phase_ticks = '0;
  logic [7:0]  tx_fail_run = '0;
  logic [7:0]  rx_fail_run = '0;
  logic        link_down = 1'b0;
  logic [15:0] tx_timeouts = '0;
  logic [15:0] rx_timeouts = '0;

  item_t       event_q[$];     // events waiting for the driver
  link_beat_t  result_q[$];    // predicted result beats, oldest first
  int          events_queued = 0;
  int          beats_seen = 0;
  int          errors = 0;
  int          stall_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          event_taken = 1'b0;
  bit          no_idle = 1'b0;
  item_t       next_event;
  result_t     got;
  link_beat_t  want;

  // Applies one event to the link model and returns the beat it produces.
  function automatic link_beat_t step_link(cmd_t cmd, logic [7:0] b);
    link_beat_t r;
    r = '0;
    case (cmd)
      CMD_START: begin
        // A start is only honored in idle; the first byte goes out at once.
        if (link_phase == PH_IDLE) begin
          r.res.tx_valid = 1'b1;
          r.res.tx_data  = b;
          bytes_left     = link_cfg.tx_count;
          phase_ticks    = '0;
          link_phase     = PH_TX;
        end
      end
      CMD_TX_SLOT: begin
        if (link_phase == PH_TX) begin
          if (bytes_left != 0) begin
            r.res.tx_valid = 1'b1;
            r.res.tx_data  = b;
            bytes_left     = bytes_left - 8'd1;
          end else begin
            // Slot with nothing left to send turns the line around.
            tx_fail_run = '0;
            bytes_left  = link_cfg.rx_count;
            reply_pos   = '0;
            phase_ticks = '0;
            link_phase  = PH_RX;
          end
        end
      end
      CMD_RX_BYTE: begin
        if (link_phase == PH_RX && bytes_left != 0) begin
          r.res.rx_valid = 1'b1;
          r.res.rx_data  = b;
          r.res.rx_index = reply_pos;
          reply_pos      = reply_pos + 8'd1;
          bytes_left     = bytes_left - 8'd1;
          if (bytes_left == 0) begin
            // A complete reply proves the link is alive again.
            rx_fail_run     = '0;
            link_down       = 1'b0;
            r.done          = 1'b1;
            r.res.done_code = DONE_REPLY;
            link_phase      = PH_IDLE;
          end
        end
      end
      CMD_TICK: begin
        if (link_phase != PH_IDLE) begin
          if (phase_ticks != 16'hFFFF) phase_ticks = phase_ticks + 16'd1;
          if (link_phase == PH_TX && phase_ticks >= link_cfg.tx_timeout) begin
            bytes_left = '0;
            if (tx_fail_run != 8'hFF) tx_fail_run = tx_fail_run + 8'd1;
            if (tx_fail_run >= link_cfg.max_tx_errors) link_down = 1'b1;
            tx_timeouts     = tx_timeouts + 16'd1;
            r.done          = 1'b1;
            r.res.done_code = DONE_TX_TIMEOUT;
            link_phase      = PH_IDLE;
          end else if (link_phase == PH_RX && phase_ticks >= link_cfg.rx_timeout) begin
            bytes_left = '0;
            if (rx_fail_run != 8'hFF) rx_fail_run = rx_fail_run + 8'd1;
            if (rx_fail_run >= link_cfg.max_rx_errors) link_down = 1'b1;
            rx_timeouts     = rx_timeouts + 16'd1;
            r.done          = 1'b1;
            r.res.done_code = DONE_RX_TIMEOUT;
            link_phase      = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.res.driver_enable  = (link_phase != PH_RX);
    r.res.link_fail      = link_down;
    r.res.phase_now      = link_phase;
    r.res.tx_error_total = tx_timeouts;
    r.res.rx_error_total = rx_timeouts;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Event driver: holds a beat until it is taken, then offers the next one
  // unless it decides to idle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || event_taken)) begin
      if (event_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 6)) begin
        next_event = event_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_event.cmd;
        in_tdata  <= next_event.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, plus one long hold-off while the
  // driver keeps offering so that the block's internal queue fills and the
  // event side stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && beats_seen >= 150 && in_tvalid) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 6);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks result beats, then predicts for the event beat taken at
  // this edge. A result never belongs to an event taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    event_taken = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        beats_seen++;
        got = result_t'(out_tdata);
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("done_valid", 16'(want.done), 16'(out_tlast));
          check_field("driver_enable", 16'(want.res.driver_enable), 16'(got.driver_enable));
          check_field("tx_valid", 16'(want.res.tx_valid), 16'(got.tx_valid));
          check_field("tx_data", 16'(want.res.tx_data), 16'(got.tx_data));
          check_field("rx_valid", 16'(want.res.rx_valid), 16'(got.rx_valid));
          check_field("rx_data", 16'(want.res.rx_data), 16'(got.rx_data));
          check_field("rx_index", 16'(want.res.rx_index), 16'(got.rx_index));
          check_field("done_code", 16'(want.res.done_code), 16'(got.done_code));
          check_field("link_fail", 16'(want.res.link_fail), 16'(got.link_fail));
          check_field("phase_now", 16'(want.res.phase_now), 16'(got.phase_now));
          check_field("tx_error_total", want.res.tx_error_total, got.tx_error_total);
          check_field("rx_error_total", want.res.rx_error_total, got.rx_error_total);
        end
      end
      if (in_tvalid && in_tready) begin
        event_taken = 1'b1;
        result_q.push_back(step_link(cmd_t'(in_tuser), in_tdata));
      end
    end
  end

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("rs485_half_duplex_master_link_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic add_event(cmd_t cmd, logic [7:0] b);
    item_t it;
    it.cmd  = cmd;
    it.data = b;
    event_q.push_back(it);
    events_queued++;
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TX_COUNT:      link_cfg.tx_count      = val[7:0];
      REG_RX_COUNT:      link_cfg.rx_count      = val[7:0];
      REG_TX_TIMEOUT:    link_cfg.tx_timeout    = val;
      REG_RX_TIMEOUT:    link_cfg.rx_timeout    = val;
      REG_MAX_TX_ERRORS: link_cfg.max_tx_errors = val[7:0];
      REG_MAX_RX_ERRORS: link_cfg.max_rx_errors = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_link(int tx_n, int rx_n, int tx_to, int rx_to, int max_tx, int max_rx);
    write_reg(REG_TX_COUNT, CfgDataW'(tx_n));
    write_reg(REG_RX_COUNT, CfgDataW'(rx_n));
    write_reg(REG_TX_TIMEOUT, CfgDataW'(tx_to));
    write_reg(REG_RX_TIMEOUT, CfgDataW'(rx_to));
    write_reg(REG_MAX_TX_ERRORS, CfgDataW'(max_tx));
    write_reg(REG_MAX_RX_ERRORS, CfgDataW'(max_rx));
  endtask

  // Waits until every queued event was taken and every result came back,
  // then lets the pipeline settle before the registers may change.
  task automatic drain;
    while (event_q.size() != 0 || in_tvalid || result_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One request/response exchange with tick beats sprinkled in. The last
  // slot turns the line around when tx_n matches the configured count.
  task automatic push_txn(int tx_n, int rx_n, int tick_pct);
    add_event(CMD_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i <= tx_n; i++) begin
      if ($urandom_range(0, 99) < tick_pct) add_event(CMD_TICK, 8'($urandom_range(0, 255)));
      add_event(CMD_TX_SLOT, 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < rx_n; i++) begin
      if ($urandom_range(0, 99) < tick_pct) add_event(CMD_TICK, 8'($urandom_range(0, 255)));
      add_event(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly complete exchanges, some cut short and left to time out, and a
  // little noise of random events.
  task automatic run_random(int n_events, int tick_pct);
    int start_cnt;
    int pick;
    start_cnt = events_queued;
    while (events_queued - start_cnt < n_events) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        push_txn(link_cfg.tx_count, link_cfg.rx_count, tick_pct);
      end else if (pick < 90) begin
        push_txn($urandom_range(0, link_cfg.tx_count), $urandom_range(0, link_cfg.rx_count),
                 tick_pct);
        repeat ($urandom_range(1, 8)) add_event(CMD_TICK, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4))
          add_event(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    link_cfg = '{tx_count: 8'd16, rx_count: 8'd17, tx_timeout: 16'd100,
                 rx_timeout: 16'd100, max_tx_errors: 8'd3, max_rx_errors: 8'd3};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass: two request bytes, a one-byte reply, short timeouts, and a
    // single transmit timeout is enough to raise the link-fail flag.
    set_link(1, 1, 3, 2, 1, 2);
    // Events that idle ignores.
    add_event(CMD_TICK, 8'h00);
    add_event(CMD_RX_BYTE, 8'h55);
    add_event(CMD_TX_SLOT, 8'hFF);
    // Clean exchange, with a start while busy, a stray received byte while
    // transmitting and a stray slot while receiving.
    add_event(CMD_START, 8'hA5);
    add_event(CMD_START, 8'h12);
    add_event(CMD_RX_BYTE, 8'h34);
    add_event(CMD_TX_SLOT, 8'hFF);
    add_event(CMD_TICK, 8'h00);
    add_event(CMD_TX_SLOT, 8'h5A);
    add_event(CMD_TX_SLOT, 8'h77);
    add_event(CMD_RX_BYTE, 8'hFF);
    // Transmit timeout sets link fail; a tick in idle changes nothing.
    add_event(CMD_START, 8'h00);
    repeat (3) add_event(CMD_TICK, 8'hFF);
    add_event(CMD_TICK, 8'h00);
    // Receive timeout below its threshold.
    add_event(CMD_START, 8'h80);
    add_event(CMD_TX_SLOT, 8'h01);
    add_event(CMD_TX_SLOT, 8'h02);
    repeat (2) add_event(CMD_TICK, 8'h00);
    // A complete reply clears link fail.
    add_event(CMD_START, 8'hC3);
    add_event(CMD_TX_SLOT, 8'h3C);
    add_event(CMD_TX_SLOT, 8'h00);
    add_event(CMD_RX_BYTE, 8'hAA);
    drain();

    // Short frames with timeouts that ticks can reach; the receiver
    // hold-off lands in this pass.
    set_link(3, 4, 6, 8, 2, 3);
    run_random(150, 15);

    // Lowest settings: no bytes after the flag, one-byte replies, any tick
    // times out and every timeout fails the link.
    set_link(0, 1, 1, 1, 1, 1);
    run_random(120, 10);

    // Largest frames both ways with timeouts out of reach, and no idling on
    // either side for the whole stretch.
    set_link(255, 255, 65535, 65535, 255, 255);
    no_idle = 1'b1;
    push_txn(255, 255, 3);
    drain();
    no_idle = 1'b0;

    // Mixed settings with a receive threshold that is never reached.
    set_link(1, 2, 4, 5, 3, 255);
    run_random(120, 20);

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("rs485_half_duplex_master_link_tb passed");
    else
      $display("rs485_half_duplex_master_link_tb failed");
    $finish;
  end

endmodule
